// File: rtl/grid_cell_shore_classifier_unit_defines.svh
// Assertion macros shared by the shore classifier RTL.
`ifndef GRID_CELL_SHORE_CLASSIFIER_UNIT_DEFINES_SVH
`define GRID_CELL_SHORE_CLASSIFIER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GCSC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gcsc check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define GCSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gcsc check failed one cycle later");

`endif

// File: rtl/gcsc_pkg.sv
// Shared types, codes and constants of the shore classifier.
package gcsc_pkg;

    localparam int unsigned GCSC_MAX_COLS = 1024;
    localparam int unsigned GCSC_MAX_ROWS = 65535;

    localparam int unsigned GCSC_DEPTH_W = 32;
    localparam int unsigned GCSC_ROWS_W = 16;
    localparam int unsigned GCSC_COLS_REG_W = 11;
    localparam int unsigned GCSC_COL_OUT_W = 10;
    localparam int unsigned GCSC_COLS_FIELD_MAX = (1 << GCSC_COLS_REG_W) - 1;

    localparam int unsigned GCSC_PADDR_W = 4;
    localparam int unsigned GCSC_PDATA_W = 32;

    localparam int unsigned GCSC_QUEUE_DEPTH = 4;
    localparam int unsigned GCSC_LEVEL_W = $clog2(GCSC_QUEUE_DEPTH + 1);

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    localparam logic [1:0] CLASS_WATER = 2'd0;
    localparam logic [1:0] CLASS_LAND = 2'd1;
    localparam logic [1:0] CLASS_NEAR_LAND = 2'd2;
    localparam logic [1:0] CLASS_GRID_EDGE = 2'd3;

    localparam logic [1:0] REG_LAND_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_GRID_ROWS = 2'd1;
    localparam logic [1:0] REG_GRID_COLS = 2'd2;

    typedef struct packed {
        logic                           operation;
        logic signed [GCSC_DEPTH_W-1:0] depth;
    } sample_t;

    typedef struct packed {
        logic [1:0]                cell_class;
        logic [GCSC_ROWS_W-1:0]    row_index;
        logic [GCSC_COL_OUT_W-1:0] col_index;
        logic                      last_cell;
    } result_t;

    // Effective grid settings plus a one-cycle restart strobe on a write to any of the three registers.
    typedef struct packed {
        logic signed [GCSC_DEPTH_W-1:0] land_threshold;
        logic [GCSC_ROWS_W-1:0]         grid_rows;
        logic [GCSC_COLS_REG_W-1:0]     grid_cols;
        logic                           restart;
    } gcsc_cfg_t;

    // Largest column count that the build supports and the register can express.
    function automatic int unsigned gcsc_cols_limit(input int unsigned max_cols);
        return (max_cols < GCSC_COLS_FIELD_MAX) ? max_cols : GCSC_COLS_FIELD_MAX;
    endfunction

endpackage

// File: rtl/gcsc_ram.sv
// Generic simple dual-port RAM with a registered read port.
module gcsc_ram #(
    parameter int unsigned WIDTH = 2,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= store_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/gcsc_regs.sv
// APB configuration registers of the shore classifier.
module gcsc_regs #(
    parameter int unsigned MAX_COLS = gcsc_pkg::GCSC_MAX_COLS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [gcsc_pkg::GCSC_PADDR_W-1:0] paddr,
    input  logic [gcsc_pkg::GCSC_PDATA_W-1:0] pwdata,
    output logic [gcsc_pkg::GCSC_PDATA_W-1:0] prdata,
    output logic                              pready,
    output gcsc_pkg::gcsc_cfg_t               cfg
);

    import gcsc_pkg::*;

    localparam int unsigned EFF_MAX = gcsc_cols_limit(MAX_COLS);

    logic signed [GCSC_DEPTH_W-1:0] land_threshold_reg;
    logic [GCSC_ROWS_W-1:0]         grid_rows_reg;
    logic [GCSC_COLS_REG_W-1:0]     grid_cols_reg;
    logic [1:0]                     reg_index;
    logic                           write_beat;

    assign reg_index = paddr[GCSC_PADDR_W-1:2];
    assign write_beat = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            land_threshold_reg <= '0;
            grid_rows_reg <= GCSC_ROWS_W'(1);
            grid_cols_reg <= GCSC_COLS_REG_W'(GCSC_MAX_COLS);
        end
        else if (write_beat)
        begin
            case (reg_index)
                REG_LAND_THRESHOLD: land_threshold_reg <= pwdata;
                REG_GRID_ROWS:      grid_rows_reg <= pwdata[GCSC_ROWS_W-1:0];
                REG_GRID_COLS:      grid_cols_reg <= pwdata[GCSC_COLS_REG_W-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_LAND_THRESHOLD: prdata = land_threshold_reg;
            REG_GRID_ROWS:      prdata = GCSC_PDATA_W'(grid_rows_reg);
            REG_GRID_COLS:      prdata = GCSC_PDATA_W'(grid_cols_reg);
            default:            prdata = '0;
        endcase
    end

    // Out-of-range sizes are clamped; any write to a known register restarts the grid.
    always_comb
    begin
        cfg.land_threshold = land_threshold_reg;

        if (grid_rows_reg == '0)
        begin
            cfg.grid_rows = GCSC_ROWS_W'(1);
        end
        else if (grid_rows_reg > GCSC_ROWS_W'(GCSC_MAX_ROWS))
        begin
            cfg.grid_rows = GCSC_ROWS_W'(GCSC_MAX_ROWS);
        end
        else
        begin
            cfg.grid_rows = grid_rows_reg;
        end

        if (grid_cols_reg == '0)
        begin
            cfg.grid_cols = GCSC_COLS_REG_W'(1);
        end
        else if (grid_cols_reg > GCSC_COLS_REG_W'(EFF_MAX))
        begin
            cfg.grid_cols = GCSC_COLS_REG_W'(EFF_MAX);
        end
        else
        begin
            cfg.grid_cols = grid_cols_reg;
        end

        cfg.restart = write_beat && (reg_index == REG_LAND_THRESHOLD ||
                                     reg_index == REG_GRID_ROWS ||
                                     reg_index == REG_GRID_COLS);
    end

endmodule

// File: rtl/gcsc_front.sv
// Front end: accepts samples and flushes, keeps the land line and classifies cells.
`include "grid_cell_shore_classifier_unit_defines.svh"

module gcsc_front #(
    parameter int unsigned MAX_COLS = gcsc_pkg::GCSC_MAX_COLS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  gcsc_pkg::gcsc_cfg_t               cfg,
    input  gcsc_pkg::sample_t                 sample,
    input  logic                              sample_valid,
    output logic                              sample_stall,
    input  logic [gcsc_pkg::GCSC_LEVEL_W-1:0] queue_level,
    output logic                              res_push,
    output gcsc_pkg::result_t                 res
);

    import gcsc_pkg::*;

    localparam int unsigned EFF_MAX = gcsc_cols_limit(MAX_COLS);
    localparam int unsigned CNT_W = $clog2(EFF_MAX + 1);
    localparam int unsigned IDX_W = $clog2(EFF_MAX);

    logic [CNT_W-1:0]       cols;
    logic [GCSC_ROWS_W-1:0] rows;

    // Position counters of the incoming sample and of the next cell to emit.
    logic [GCSC_ROWS_W-1:0] in_row_reg, in_row_next;
    logic [IDX_W-1:0]       in_col_reg, in_col_next;
    logic [GCSC_ROWS_W-1:0] em_row_reg, em_row_next;
    logic [IDX_W-1:0]       em_col_reg, em_col_next;

    // Stage one: the item whose line word is being read.
    logic                   s1_valid_reg;
    logic                   s1_push_reg;
    logic                   s1_emit_reg;
    logic                   s1_land_reg;
    logic [IDX_W-1:0]       s1_col_reg;
    logic [GCSC_ROWS_W-1:0] s1_row_reg;
    logic [IDX_W-1:0]       s1_ecol_reg;
    logic                   s1_edge_reg;
    logic                   s1_top_reg;
    logic                   s1_last_reg;
    logic                   s1_bot_sel_reg;

    // Land columns of the two previous samples: bit 2 two rows up, bit 1 one row up,
    // bit 0 the sample row.
    logic [2:0] p1_reg, p2_reg;
    logic       byp_hit_reg;
    logic [1:0] byp_data_reg;

    logic                   accept;
    logic                   grid_full;
    logic                   push_ok, push_emit, flush_ok, em_last;
    logic [CNT_W-1:0]       in_col_inc, em_col_inc;
    logic [GCSC_ROWS_W-1:0] em_row_adv;
    logic [IDX_W-1:0]       em_col_adv;
    logic                   land;
    logic                   ram_re, ram_we;
    logic [IDX_W-1:0]       rd_addr;
    logic [1:0]             ram_rdata, rd_word, ram_wdata;
    logic [2:0]             col_now;
    logic                   self_land, near_low, near_any;
    logic [1:0]             cls;
    logic [GCSC_LEVEL_W:0]  pending;

    assign cols = CNT_W'(cfg.grid_cols);
    assign rows = cfg.grid_rows;

    assign pending = {1'b0, queue_level} + (GCSC_LEVEL_W + 1)'(res_push);
    assign sample_stall = pending >= (GCSC_LEVEL_W + 1)'(GCSC_QUEUE_DEPTH);
    assign accept = sample_valid && !sample_stall;

    assign grid_full = (in_row_reg == rows);
    assign push_ok = accept && (sample.operation == OP_PUSH) && !grid_full;
    assign flush_ok = accept && (sample.operation == OP_FLUSH) && grid_full &&
                      (em_row_reg < rows);
    // A push emits once more than one row of samples has arrived.
    assign push_emit = (in_row_reg >= GCSC_ROWS_W'(2)) ||
                       ((in_row_reg == GCSC_ROWS_W'(1)) && (in_col_reg != '0));
    assign em_last = (em_row_reg == rows - GCSC_ROWS_W'(1)) &&
                     (CNT_W'(em_col_reg) == cols - CNT_W'(1));

    assign land = $signed(sample.depth) >= $signed(cfg.land_threshold);

    assign in_col_inc = CNT_W'(in_col_reg) + CNT_W'(1);
    assign em_col_inc = CNT_W'(em_col_reg) + CNT_W'(1);

    always_comb
    begin
        if (em_col_inc == cols)
        begin
            em_col_adv = '0;
            em_row_adv = em_row_reg + GCSC_ROWS_W'(1);
        end
        else
        begin
            em_col_adv = em_col_inc[IDX_W-1:0];
            em_row_adv = em_row_reg;
        end
    end

    always_comb
    begin
        in_row_next = in_row_reg;
        in_col_next = in_col_reg;
        em_row_next = em_row_reg;
        em_col_next = em_col_reg;
        if (cfg.restart)
        begin
            in_row_next = '0;
            in_col_next = '0;
            em_row_next = '0;
            em_col_next = '0;
        end
        else if (push_ok)
        begin
            if (in_col_inc == cols)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + GCSC_ROWS_W'(1);
            end
            else
            begin
                in_col_next = in_col_inc[IDX_W-1:0];
            end
            if (push_emit)
            begin
                em_row_next = em_row_adv;
                em_col_next = em_col_adv;
            end
        end
        else if (flush_ok)
        begin
            if (em_last)
            begin
                in_row_next = '0;
                in_col_next = '0;
                em_row_next = '0;
                em_col_next = '0;
            end
            else
            begin
                em_row_next = em_row_adv;
                em_col_next = em_col_adv;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_row_reg <= '0;
            in_col_reg <= '0;
            em_row_reg <= '0;
            em_col_reg <= '0;
            s1_valid_reg <= 1'b0;
            byp_hit_reg <= 1'b0;
        end
        else
        begin
            in_row_reg <= in_row_next;
            in_col_reg <= in_col_next;
            em_row_reg <= em_row_next;
            em_col_reg <= em_col_next;
            s1_valid_reg <= ram_re;
            byp_hit_reg <= ram_re && ram_we && (rd_addr == s1_col_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ram_re)
        begin
            s1_push_reg <= push_ok;
            s1_emit_reg <= push_ok ? push_emit : 1'b1;
            s1_land_reg <= land;
            s1_col_reg <= in_col_reg;
            s1_row_reg <= em_row_reg;
            s1_ecol_reg <= em_col_reg;
            s1_edge_reg <= (em_col_reg == '0) ||
                           (CNT_W'(em_col_reg) == cols - CNT_W'(1)) ||
                           (em_row_reg == rows - GCSC_ROWS_W'(1));
            s1_top_reg <= (em_row_reg == '0);
            s1_last_reg <= flush_ok && em_last;
            s1_bot_sel_reg <= (em_row_reg == rows - GCSC_ROWS_W'(1));
            byp_data_reg <= ram_wdata;
        end
        if (ram_we)
        begin
            p2_reg <= p1_reg;
            p1_reg <= col_now;
        end
    end

    // The line keeps two land bits per column: one row up and the sample row.
    assign ram_re = push_ok || flush_ok;
    assign rd_addr = (sample.operation == OP_FLUSH) ? em_col_reg : in_col_reg;
    assign ram_we = s1_valid_reg && s1_push_reg;
    assign rd_word = byp_hit_reg ? byp_data_reg : ram_rdata;
    assign ram_wdata = {rd_word[0], s1_land_reg};
    assign col_now = {rd_word, s1_land_reg};

    gcsc_ram #(
        .WIDTH(2),
        .DEPTH(EFF_MAX)
    ) u_line (
        .clk  (clk),
        .we   (ram_we),
        .waddr(s1_col_reg),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(rd_addr),
        .rdata(ram_rdata)
    );

    // A pushed sample classifies the cell one row and one column behind it, whose own
    // bit sits in the middle of the previous column. Flushed cells lie on the last row
    // or the right edge, so only their own bit matters.
    always_comb
    begin
        if (s1_push_reg)
        begin
            self_land = p1_reg[1];
        end
        else
        begin
            self_land = s1_bot_sel_reg ? rd_word[0] : rd_word[1];
        end
        near_low = p2_reg[0] | col_now[0];
        near_any = near_low | p2_reg[2] | col_now[2];

        if (self_land)
        begin
            cls = CLASS_LAND;
        end
        else if (s1_edge_reg)
        begin
            cls = CLASS_GRID_EDGE;
        end
        else if (s1_top_reg)
        begin
            cls = near_low ? CLASS_NEAR_LAND : CLASS_GRID_EDGE;
        end
        else
        begin
            cls = near_any ? CLASS_NEAR_LAND : CLASS_WATER;
        end
    end

    assign res_push = s1_valid_reg && s1_emit_reg;
    assign res.cell_class = cls;
    assign res.row_index = s1_row_reg;
    assign res.col_index = GCSC_COL_OUT_W'(s1_ecol_reg);
    assign res.last_cell = s1_last_reg;

    `GCSC_ASSERT_NOW(a_flush_class, clk, rst_n, res_push && !s1_push_reg, res.cell_class == CLASS_LAND || res.cell_class == CLASS_GRID_EDGE)
    `GCSC_ASSERT_NOW(a_last_from_flush, clk, rst_n, res_push && res.last_cell, !s1_push_reg)
    `GCSC_ASSERT_NOW(a_rows_bound, clk, rst_n, 1'b1, in_row_reg <= rows && em_row_reg < rows)

endmodule

// File: rtl/gcsc_queue.sv
// Back end: short result queue whose head drives the result channel.
`include "grid_cell_shore_classifier_unit_defines.svh"

module gcsc_queue (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    input  gcsc_pkg::result_t                 push_data,
    output logic [gcsc_pkg::GCSC_LEVEL_W-1:0] level,
    output logic                              result_valid,
    input  logic                              result_stall,
    output gcsc_pkg::result_t                 result
);

    import gcsc_pkg::*;

    localparam int unsigned PTR_W = $clog2(GCSC_QUEUE_DEPTH);

    result_t                 slot_reg [GCSC_QUEUE_DEPTH];
    logic [PTR_W-1:0]        wr_ptr_reg, rd_ptr_reg;
    logic [GCSC_LEVEL_W-1:0] count_reg;
    logic                    pop;

    assign result_valid = (count_reg != '0);
    assign pop = result_valid && !result_stall;
    assign result = slot_reg[rd_ptr_reg];
    assign level = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + GCSC_LEVEL_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - GCSC_LEVEL_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    `GCSC_ASSERT_NOW(a_level_bound, clk, rst_n, 1'b1, count_reg <= GCSC_LEVEL_W'(GCSC_QUEUE_DEPTH))
    `GCSC_ASSERT_NOW(a_no_overflow, clk, rst_n, push, count_reg < GCSC_LEVEL_W'(GCSC_QUEUE_DEPTH))
    `GCSC_ASSERT_NEXT(a_pop_drains, clk, rst_n, pop && !push, count_reg == $past(count_reg) - GCSC_LEVEL_W'(1))

endmodule

// File: rtl/grid_cell_shore_classifier_unit.sv
// Top level of the grid cell shore classifier.
//
//   channel   direction  beat contents                         handshake
//   sample    in         operation, depth (sample_t)           sample_valid / sample_stall
//   result    out        class, row, column, last (result_t)   result_valid / result_stall
//   config    in         APB write/read of three registers     psel, penable, pready
//
// The block takes one beat per cycle while sample_stall is low; a result passes through
// the stage-one registers, fed by the registered read of the column line memory, into the queue.
// Reset clears the counters, the pipeline and the queue; the line memory is not cleared,
// because bits read before they are written in the current grid never decide a class.
// sample_stall rises only when the four-entry result queue, counting the beat in flight,
// is full, so a stalled result side backs up into the sample side once four results wait.
module grid_cell_shore_classifier_unit #(
    parameter int unsigned MAX_COLS = gcsc_pkg::GCSC_MAX_COLS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [gcsc_pkg::GCSC_PADDR_W-1:0] paddr,
    input  logic [gcsc_pkg::GCSC_PDATA_W-1:0] pwdata,
    output logic [gcsc_pkg::GCSC_PDATA_W-1:0] prdata,
    output logic                              pready,
    input  gcsc_pkg::sample_t                 sample,
    input  logic                              sample_valid,
    output logic                              sample_stall,
    output gcsc_pkg::result_t                 result,
    output logic                              result_valid,
    input  logic                              result_stall
);

    import gcsc_pkg::*;

    // Effective grid size, land threshold and the restart strobe of a register write.
    gcsc_cfg_t               cfg;
    // Classified cells travel from the front end into the queue one per cycle at most.
    logic                    res_push;
    result_t                 res;
    logic [GCSC_LEVEL_W-1:0] queue_level;

    gcsc_regs #(
        .MAX_COLS(MAX_COLS)
    ) u_regs (
        .clk    (clk),
        .rst_n  (rst_n),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready),
        .cfg    (cfg)
    );

    // The front end holds the sample and emit counters, the two-row land line and the
    // three-column window, and classifies at most one cell per beat.
    gcsc_front #(
        .MAX_COLS(MAX_COLS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .sample      (sample),
        .sample_valid(sample_valid),
        .sample_stall(sample_stall),
        .queue_level (queue_level),
        .res_push    (res_push),
        .res         (res)
    );

    // The queue decouples the result side so that it can stall without holding up
    // the classification of beats already accepted.
    gcsc_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (res_push),
        .push_data   (res),
        .level       (queue_level),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result      (result)
    );

endmodule
